// File: rtl/bus_slave_register_map_defines.svh
// ----------------------------------------------------------------------------
// bus_slave_register_map_defines
// Assertion macros used by the register map top level.
// ----------------------------------------------------------------------------
`ifndef BUS_SLAVE_REGISTER_MAP_DEFINES_SVH
`define BUS_SLAVE_REGISTER_MAP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BSRM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BSRM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bsrm_pkg.sv
// ----------------------------------------------------------------------------
// bsrm_pkg
// Types and command codes of the bus slave register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsrm_pkg;

   localparam int RX_KEPT = 3;

   localparam logic [3:0] CMD_NONE       = 4'h0;
   localparam logic [3:0] CMD_WRITE_BYTE = 4'h1;
   localparam logic [3:0] CMD_WRITE_WORD = 4'h2;
   localparam logic [3:0] CMD_READ_BYTE  = 4'h4;
   localparam logic [3:0] CMD_READ_WORD  = 4'h8;

   typedef struct packed {
      logic       operation;
      logic [5:0] byte_count;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic [7:0] fourth_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic write_hi;
      logic read_lo;
      logic read_hi;
      logic emit_mem;
      logic emit_zero;
      logic last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic write_ok;
      logic read_req;
      logic rd_byte_pend;
      logic rd_word_pend;
      logic wr_word;
   } ctrl_status_type;

endpackage

`default_nettype wire

// File: rtl/bus_slave_register_map.sv
// ----------------------------------------------------------------------------
// bus_slave_register_map
// Register map of up to 16 bytes behind a byte bus, top level.
// ----------------------------------------------------------------------------
// Usage:
//   Present a transfer on req_item and raise start; the word is taken at the
//   clock edge where start is high and busy is low.
//   A write transfer (operation 0) of at most MAX_RX_BYTES bytes updates the
//   receive buffer and is decoded; it returns nothing. Longer writes are
//   dropped and leave busy low. Accepted writes hold busy through the decode
//   state, and a word write also through the high-byte write state.
//   A read transfer (operation 1) returns one or two words on rsp_item, each
//   marked by rsp_strobe for a single cycle, last_byte on the final one.
//   With no read pending a zero byte follows in the cycle after acceptance
//   and busy stays low. A byte read passes the fetch state, which reads the
//   storage, and the low-byte state, which emits its word through the
//   response register; a word read also passes the high-byte state for its
//   second word. Busy covers the fetch from the single storage read port.
//   One item is handled at a time. The receiver cannot stall; every word is
//   offered once. Reset clears the receive buffer, the pending read and the
//   storage valid flags, so storage not written since reset reads as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bus_slave_register_map_defines.svh"

module bus_slave_register_map #(
   parameter int MAP_BYTES    = 16,
   parameter int MAX_RX_BYTES = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire bsrm_pkg::req_type req_item,
   output bsrm_pkg::rsp_type      rsp_item,
   output logic                   rsp_strobe
);

   bsrm_pkg::ctrl_cmd_type    cmd;
   bsrm_pkg::ctrl_status_type status;

   bsrm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   bsrm_datapath #(
      .MAP_BYTES    (MAP_BYTES),
      .MAX_RX_BYTES (MAX_RX_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_item   (rsp_item),
      .rsp_strobe (rsp_strobe)
   );

   `BSRM_ASSERT_NEXT(a_write_silent, start && !busy && !req_item.operation, !rsp_strobe, "write transfer produced a response")
   `BSRM_ASSERT_NEXT(a_idle_read, start && !busy && req_item.operation && !status.rd_byte_pend && !status.rd_word_pend, rsp_strobe && rsp_item.last_byte && (rsp_item.read_data == 8'h00), "read with nothing pending did not return a zero byte")
   `BSRM_ASSERT_NEXT(a_word_pair, rsp_strobe && !rsp_item.last_byte, rsp_strobe && rsp_item.last_byte, "first byte of a word read not followed by the last byte")
   `BSRM_ASSERT_IMP(a_busy_strobe, rsp_strobe && !rsp_item.last_byte, busy, "word read released busy between its two bytes")

endmodule

`default_nettype wire

// File: rtl/bsrm_datapath.sv
// ----------------------------------------------------------------------------
// bsrm_datapath
// Receive buffer, command decode, register storage and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsrm_datapath #(
   parameter int MAP_BYTES    = 16,
   parameter int MAX_RX_BYTES = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bsrm_pkg::req_type         req_item,
   input  wire bsrm_pkg::ctrl_cmd_type    cmd,
   output bsrm_pkg::ctrl_status_type      status,
   output bsrm_pkg::rsp_type              rsp_item,
   output logic                           rsp_strobe
);

   localparam int         AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam logic [4:0] MAP5   = 5'(MAP_BYTES);
   localparam logic [5:0] MAX_RX = 6'(MAX_RX_BYTES);

   logic [7:0]          rx_ff [bsrm_pkg::RX_KEPT];
   logic [7:0]          rx_in [bsrm_pkg::RX_KEPT];
   logic [7:0]          req_bytes [bsrm_pkg::RX_KEPT];
   logic [3:0]          pend_cmd_ff, pend_cmd_in;
   logic [3:0]          pend_reg_ff, pend_reg_in;
   logic [MAP_BYTES-1:0] valid_ff, valid_in;
   logic [7:0]          mem [MAP_BYTES];
   logic [7:0]          rd_q_ff;
   logic                rd_valid_ff;
   bsrm_pkg::rsp_type   rsp_ff, rsp_in;
   logic                strobe_ff, strobe_in;

   logic [3:0]          dec_reg;
   logic [3:0]          dec_nib;
   logic [3:0]          dec_cmd;
   logic                reg_in_map;
   logic                word_fits;
   logic                mem_we;
   logic [AW-1:0]       waddr;
   logic [7:0]          wdata;
   logic [AW-1:0]       raddr;
   logic                rd_en;
   logic [AW-1:0]       pend_idx;

   assign req_bytes[0] = req_item.first_byte;
   assign req_bytes[1] = req_item.second_byte;
   assign req_bytes[2] = req_item.third_byte;

   // decode byte 0 of the receive buffer
   always_comb begin
      dec_reg    = rx_ff[0][3:0];
      dec_nib    = rx_ff[0][7:4];
      reg_in_map = {1'b0, dec_reg} < MAP5;
      word_fits  = ({1'b0, dec_reg} + 5'd1) < MAP5;
      dec_cmd    = bsrm_pkg::CMD_NONE;
      if (reg_in_map) begin
         unique case (dec_nib) inside
            bsrm_pkg::CMD_WRITE_BYTE, bsrm_pkg::CMD_WRITE_WORD,
            bsrm_pkg::CMD_READ_BYTE: begin
               dec_cmd = dec_nib;
            end
            bsrm_pkg::CMD_READ_WORD: begin
               dec_cmd = word_fits ? dec_nib : bsrm_pkg::CMD_NONE;
            end
            default: begin
               dec_cmd = bsrm_pkg::CMD_NONE;
            end
         endcase
      end
   end

   assign pend_idx = pend_reg_ff[AW-1:0];

   always_comb begin
      status.write_ok     = !req_item.operation && (req_item.byte_count <= MAX_RX);
      status.read_req     = req_item.operation;
      status.rd_byte_pend = pend_cmd_ff == bsrm_pkg::CMD_READ_BYTE;
      status.rd_word_pend = pend_cmd_ff == bsrm_pkg::CMD_READ_WORD;
      status.wr_word      = (dec_cmd == bsrm_pkg::CMD_WRITE_WORD) && word_fits;
   end

   always_comb begin
      for (int i = 0; i < bsrm_pkg::RX_KEPT; i++) begin
         rx_in[i] = rx_ff[i];
         if (cmd.capture && (6'(i) < req_item.byte_count)) begin
            rx_in[i] = req_bytes[i];
         end
      end
      pend_cmd_in = cmd.decode ? dec_cmd : pend_cmd_ff;
      pend_reg_in = cmd.decode ? dec_reg : pend_reg_ff;
   end

   // storage write and read ports
   always_comb begin
      mem_we = cmd.write_hi ||
               (cmd.decode && ((dec_cmd == bsrm_pkg::CMD_WRITE_BYTE) || status.wr_word));
      waddr  = cmd.write_hi ? AW'(pend_idx + AW'(1)) : dec_reg[AW-1:0];
      wdata  = cmd.write_hi ? rx_ff[2] : rx_ff[1];
      rd_en  = cmd.read_lo || cmd.read_hi;
      raddr  = cmd.read_hi ? AW'(pend_idx + AW'(1)) : pend_idx;
      valid_in = valid_ff;
      if (mem_we) begin
         valid_in[waddr] = 1'b1;
      end
   end

   always_comb begin
      strobe_in          = cmd.emit_mem || cmd.emit_zero;
      rsp_in.last_byte   = cmd.last;
      rsp_in.read_data   = (cmd.emit_mem && rd_valid_ff) ? rd_q_ff : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bsrm_pkg::RX_KEPT; i++) begin
            rx_ff[i] <= 8'h00;
         end
         pend_cmd_ff <= bsrm_pkg::CMD_NONE;
         pend_reg_ff <= 4'h0;
         valid_ff    <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         rx_ff       <= rx_in;
         pend_cmd_ff <= pend_cmd_in;
         pend_reg_ff <= pend_reg_in;
         valid_ff    <= valid_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_q_ff     <= mem[raddr];
         rd_valid_ff <= valid_ff[raddr];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_item   = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

// File: rtl/bsrm_ctrl.sv
// ----------------------------------------------------------------------------
// bsrm_ctrl
// Sequencer for write decode, word write and byte or word read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsrm_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire bsrm_pkg::ctrl_status_type status,
   output logic                           busy,
   output bsrm_pkg::ctrl_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_WR_HI    = 3'd2;
   localparam logic [2:0] S_RD_FETCH = 3'd3;
   localparam logic [2:0] S_RD_LO    = 3'd4;
   localparam logic [2:0] S_RD_HI    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign busy   = state_ff != S_IDLE;
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (status.read_req) begin
                  if (status.rd_byte_pend || status.rd_word_pend) begin
                     state_in = S_RD_FETCH;
                  end else begin
                     cmd.emit_zero = 1'b1;
                     cmd.last      = 1'b1;
                  end
               end else if (status.write_ok) begin
                  cmd.capture = 1'b1;
                  state_in    = S_DECODE;
               end
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = status.wr_word ? S_WR_HI : S_IDLE;
         end
         S_WR_HI: begin
            cmd.write_hi = 1'b1;
            state_in     = S_IDLE;
         end
         S_RD_FETCH: begin
            cmd.read_lo = 1'b1;
            state_in    = S_RD_LO;
         end
         S_RD_LO: begin
            cmd.emit_mem = 1'b1;
            cmd.last     = !status.rd_word_pend;
            cmd.read_hi  = status.rd_word_pend;
            state_in     = status.rd_word_pend ? S_RD_HI : S_IDLE;
         end
         S_RD_HI: begin
            cmd.emit_mem = 1'b1;
            cmd.last     = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sim/tb_bus_slave_register_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bus_slave_register_map
// Self-checking bench for the byte bus register map. A clocked driver feeds
// transfers from a queue, a predictor tracks the map, receive buffer and
// pending read to build the expected read replies, and a clocked monitor
// compares every strobed reply against them in order.
// ----------------------------------------------------------------------------

module tb_bus_slave_register_map;

   localparam int MAP_BYTES    = 16;
   localparam int MAX_RX_BYTES = 4;
   localparam int IDLE_LIMIT   = 2000;
   localparam int GAP_MAX      = 12;
   localparam logic [3:0] CMD_OTHER = 4'hC;
   localparam logic [3:0] REG_TOP   = 4'hF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   bsrm_pkg::req_type req_item = '0;
   logic              busy;
   bsrm_pkg::rsp_type rsp_item;
   logic              rsp_strobe;

   bsrm_pkg::req_type transfer_queue[$];
   bsrm_pkg::rsp_type expected_replies[$];

   logic [7:0] map_model[MAP_BYTES];
   logic [7:0] rx_model[bsrm_pkg::RX_KEPT];
   logic [3:0] armed_cmd;
   logic [3:0] armed_reg;

   int error_count;
   int words_sent;
   int reads_sent;
   int replies_checked;
   int gap_left;
   bit burst_mode;
   int idle_cycles;

   bus_slave_register_map i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_item   (rsp_item),
      .rsp_strobe (rsp_strobe)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
      error_count++;
   endtask

   task automatic apply_transfer(input bsrm_pkg::req_type t);
      logic [3:0] cmd;
      int         rg;
      if (!t.operation) begin
         if (t.byte_count <= MAX_RX_BYTES) begin
            if (t.byte_count > 0) rx_model[0] = t.first_byte;
            if (t.byte_count > 1) rx_model[1] = t.second_byte;
            if (t.byte_count > 2) rx_model[2] = t.third_byte;
            cmd = rx_model[0][7:4];
            rg  = int'(rx_model[0][3:0]);
            if (rg >= MAP_BYTES) cmd = bsrm_pkg::CMD_NONE;
            case (cmd)
               bsrm_pkg::CMD_WRITE_BYTE: map_model[rg] = rx_model[1];
               bsrm_pkg::CMD_WRITE_WORD: begin
                  if (rg + 1 < MAP_BYTES) begin
                     map_model[rg]     = rx_model[1];
                     map_model[rg + 1] = rx_model[2];
                  end
               end
               bsrm_pkg::CMD_READ_BYTE: ;
               bsrm_pkg::CMD_READ_WORD: begin
                  if (rg + 1 >= MAP_BYTES) cmd = bsrm_pkg::CMD_NONE;
               end
               default: cmd = bsrm_pkg::CMD_NONE;
            endcase
            armed_cmd = cmd;
            armed_reg = rg[3:0];
         end
      end else begin
         rg = int'(armed_reg);
         if (armed_cmd == bsrm_pkg::CMD_READ_BYTE && rg < MAP_BYTES) begin
            expected_replies.push_back('{read_data: map_model[rg], last_byte: 1'b1});
         end else if (armed_cmd == bsrm_pkg::CMD_READ_WORD && rg + 1 < MAP_BYTES) begin
            expected_replies.push_back('{read_data: map_model[rg], last_byte: 1'b0});
            expected_replies.push_back('{read_data: map_model[rg + 1], last_byte: 1'b1});
         end else begin
            expected_replies.push_back('{read_data: 8'h00, last_byte: 1'b1});
         end
      end
   endtask

   function automatic bsrm_pkg::req_type rand_req();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(bsrm_pkg::req_type)-1:0];
   endfunction

   function automatic bsrm_pkg::req_type write_xfer(input int count, input logic [3:0] cmd,
                                                    input logic [3:0] rg,
                                                    input logic [7:0] d1,
                                                    input logic [7:0] d2);
      bsrm_pkg::req_type t;
      t.operation   = 1'b0;
      t.byte_count  = count[5:0];
      t.first_byte  = {cmd, rg};
      t.second_byte = d1;
      t.third_byte  = d2;
      t.fourth_byte = 8'($urandom);
      return t;
   endfunction

   function automatic bsrm_pkg::req_type read_xfer();
      bsrm_pkg::req_type t;
      t             = rand_req();
      t.operation   = 1'b1;
      return t;
   endfunction

   function automatic logic [3:0] pick_reg();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? REG_TOP : 4'h0;
      return 4'($urandom_range(0, MAP_BYTES - 1));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && busy === 1'b0) begin
            apply_transfer(req_item);
            words_sent++;
            if (req_item.operation) reads_sent++;
            if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
            gap_left = burst_mode ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (!start || busy === 1'b0) begin
            if (gap_left > 0) begin
               start <= 1'b0;
               gap_left--;
            end else if (transfer_queue.size() != 0) begin
               req_item <= transfer_queue.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected reply", 0, int'(rsp_item));
         end else begin
            if (rsp_item.read_data !== expected_replies[0].read_data)
               report_mismatch("read_data", int'(expected_replies[0].read_data),
                               int'(rsp_item.read_data));
            if (rsp_item.last_byte !== expected_replies[0].last_byte)
               report_mismatch("last_byte", int'(expected_replies[0].last_byte),
                               int'(rsp_item.last_byte));
            void'(expected_replies.pop_front());
            replies_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_bus_slave_register_map: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int         kind;
      int         n;
      logic [3:0] rg;
      logic [3:0] cmd;

      for (int i = 0; i < MAP_BYTES; i++) map_model[i] = 8'h00;
      for (int i = 0; i < bsrm_pkg::RX_KEPT; i++) rx_model[i] = 8'h00;
      armed_cmd = bsrm_pkg::CMD_NONE;
      armed_reg = 4'h0;

      // directed
      transfer_queue.push_back(read_xfer());
      transfer_queue.push_back(write_xfer(0, bsrm_pkg::CMD_READ_BYTE, REG_TOP, 8'hFF, 8'hFF));
      transfer_queue.push_back(read_xfer());
      transfer_queue.push_back(write_xfer(2, bsrm_pkg::CMD_WRITE_BYTE, 4'h0, 8'hFF, 8'h00));
      transfer_queue.push_back(read_xfer());
      transfer_queue.push_back(write_xfer(1, bsrm_pkg::CMD_READ_BYTE, 4'h0, 8'h00, 8'h00));
      transfer_queue.push_back(read_xfer());
      transfer_queue.push_back(write_xfer(3, bsrm_pkg::CMD_WRITE_WORD, 4'hE, 8'hA5, 8'h5A));
      transfer_queue.push_back(write_xfer(1, bsrm_pkg::CMD_READ_WORD, 4'hE, 8'h00, 8'h00));
      transfer_queue.push_back(read_xfer());
      transfer_queue.push_back(write_xfer(4, bsrm_pkg::CMD_WRITE_WORD, REG_TOP, 8'h11, 8'h22));
      transfer_queue.push_back(write_xfer(1, bsrm_pkg::CMD_READ_WORD, REG_TOP, 8'h00, 8'h00));
      transfer_queue.push_back(read_xfer());
      transfer_queue.push_back(write_xfer(2, bsrm_pkg::CMD_WRITE_BYTE, REG_TOP, 8'h3C, 8'h00));
      transfer_queue.push_back(write_xfer(1, bsrm_pkg::CMD_READ_BYTE, REG_TOP, 8'h00, 8'h00));
      transfer_queue.push_back(read_xfer());
      transfer_queue.push_back(write_xfer(5, bsrm_pkg::CMD_WRITE_BYTE, REG_TOP, 8'h00, 8'h00));
      transfer_queue.push_back(write_xfer(63, bsrm_pkg::CMD_READ_WORD, 4'h0, 8'h00, 8'h00));
      transfer_queue.push_back(read_xfer());
      transfer_queue.push_back(write_xfer(0, bsrm_pkg::CMD_WRITE_BYTE, 4'h0, 8'h00, 8'h00));
      transfer_queue.push_back(read_xfer());
      transfer_queue.push_back(write_xfer(4, CMD_OTHER, 4'h3, 8'h00, 8'h00));
      transfer_queue.push_back(read_xfer());
      transfer_queue.push_back(write_xfer(1, bsrm_pkg::CMD_READ_WORD, 4'h0, 8'h00, 8'h00));
      transfer_queue.push_back(read_xfer());

      // random, mostly well-formed sequences
      while (transfer_queue.size() < 725) begin
         kind = $urandom_range(0, 99);
         rg   = pick_reg();
         if (kind < 20) begin
            transfer_queue.push_back(write_xfer($urandom_range(2, 4), bsrm_pkg::CMD_WRITE_BYTE,
                                                rg, 8'($urandom), 8'($urandom)));
         end else if (kind < 35) begin
            transfer_queue.push_back(write_xfer($urandom_range(3, 4), bsrm_pkg::CMD_WRITE_WORD,
                                                rg, 8'($urandom), 8'($urandom)));
         end else if (kind < 80) begin
            cmd = $urandom_range(0, 1) ? bsrm_pkg::CMD_READ_BYTE : bsrm_pkg::CMD_READ_WORD;
            transfer_queue.push_back(write_xfer($urandom_range(1, 4), cmd, rg,
                                                8'($urandom), 8'($urandom)));
            n = $urandom_range(1, 2);
            repeat (n) transfer_queue.push_back(read_xfer());
         end else if (kind < 85) begin
            transfer_queue.push_back(write_xfer($urandom_range(0, 1), 4'($urandom), rg,
                                                8'($urandom), 8'($urandom)));
            transfer_queue.push_back(read_xfer());
         end else if (kind < 90) begin
            transfer_queue.push_back(write_xfer($urandom_range(5, 63), 4'($urandom), rg,
                                                8'($urandom), 8'($urandom)));
            transfer_queue.push_back(read_xfer());
         end else if (kind < 95) begin
            transfer_queue.push_back(write_xfer($urandom_range(0, 4), 4'($urandom), rg,
                                                8'($urandom), 8'($urandom)));
            transfer_queue.push_back(read_xfer());
         end else begin
            transfer_queue.push_back(rand_req());
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (transfer_queue.size() != 0 || start === 1'b1 || busy === 1'b1) @(negedge clock);
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d transfers, %0d of them reads; checked %0d read replies.",
               words_sent, reads_sent, replies_checked);
      if (error_count == 0) begin
         $display("tb_bus_slave_register_map: done, clean");
      end else begin
         $display("tb_bus_slave_register_map: done, errors");
      end
      $finish;
   end

endmodule
